// ===== sv/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// Used by the cell, the top level and the checker; depends on nothing.
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic do_insert;
        logic do_remove;
        logic occupied;
        logic at_tail;
    } cell_ctrl_t;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the sorted cell row: holds an entry and shifts it to a neighbor.
// Depends on spq_pkg.
module spq_cell (
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t     new_entry,
    input  spq_pkg::entry_t     left_entry,
    input  logic                left_take,
    input  spq_pkg::entry_t     right_entry,
    output spq_pkg::entry_t     entry,
    output logic                take
);
    import spq_pkg::*;

    entry_t entry_reg;
    logic   greater;

    // A held entry with a strictly larger priority gives way to the new one,
    // which keeps equal priorities in arrival order.
    always_comb
    begin
        greater = entry_reg.prio > new_entry.prio;
        take    = ctrl.occupied ? greater : ctrl.at_tail;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.do_insert && take)
        begin
            entry_reg <= left_take ? left_entry : new_entry;
        end
        else if (ctrl.do_remove)
        begin
            entry_reg <= right_entry;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: a row of spq_cell slots, the fill
// count and the result register. Depends on spq_pkg and spq_cell.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------------
//   input   | in_valid / in_stall  | cmd, item_value, item_priority
//   output  | out_valid / out_stall| removed_value, removed_priority, status, occupancy
//
// For every command all cells compare their priority with the new one in
// parallel and shift left or right by one slot in the same edge, so a
// transfer can be taken in every cycle while the result register drains.
// The result of a command appears in the result register in the cycle after
// its transfer. A stalled result holds the input stalled as well.
// Reset clears the fill count and the result valid flag; slot contents are
// only ever read below the fill count and need no reset.
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic signed [spq_pkg::DATA_W-1:0] item_value,
    input  logic signed [spq_pkg::DATA_W-1:0] item_priority,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [spq_pkg::DATA_W-1:0] removed_value,
    output logic signed [spq_pkg::DATA_W-1:0] removed_priority,
    output logic [1:0]                        status,
    output logic [spq_pkg::OCC_W-1:0]         occupancy
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg;
    entry_t        removed_reg, removed_next;
    logic [1:0]    status_reg, status_next;
    logic [OCC_W-1:0] occupancy_reg;

    logic   accept;
    logic   full;
    logic   empty;
    logic   do_insert;
    logic   do_remove;
    entry_t new_entry;
    entry_t cell_entry [CAPACITY];
    logic   cell_take  [CAPACITY];

    // The input waits only while a finished result is still held back.
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign do_insert = accept && (cmd == CMD_INSERT) && !full;
    assign do_remove = accept && (cmd == CMD_REMOVE) && !empty;

    assign new_entry.value = item_value;
    assign new_entry.prio  = item_priority;

    // Each cell knows whether it holds an entry and whether it is the first
    // free slot; the first cell that takes receives the new entry and the
    // ones behind it take their left neighbor's entry.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        entry_t     left_entry;
        logic       left_take;
        entry_t     right_entry;

        always_comb
        begin
            ctrl.do_insert = do_insert;
            ctrl.do_remove = do_remove;
            ctrl.occupied  = CW'(i) < count_reg;
            ctrl.at_tail   = CW'(i) == count_reg;
        end

        if (i == 0)
        begin : g_head
            assign left_entry = '0;
            assign left_take  = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_take  = cell_take[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .left_take   (left_take),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .take        (cell_take[i])
        );
    end

    always_comb
    begin
        count_next   = count_reg;
        removed_next = '0;
        status_next  = STATUS_DONE;
        case (cmd)
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = STATUS_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (empty)
                begin
                    status_next = STATUS_UNDERFLOW;
                end
                else
                begin
                    removed_next = cell_entry[0];
                    count_next   = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next = STATUS_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg   <= removed_next;
            status_reg    <= status_next;
            occupancy_reg <= OCC_W'(count_next);
        end
    end

    assign out_valid        = out_valid_reg;
    assign removed_value    = removed_reg.value;
    assign removed_priority = removed_reg.prio;
    assign status           = status_reg;
    assign occupancy        = occupancy_reg;

endmodule

// ===== sv/spq_checker.sv =====
// Port-level checks for sorted_priority_queue, attached by the bind below.
// Depends on spq_pkg and on the port names of the top level.
module spq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [spq_pkg::DATA_W-1:0] removed_value,
    input logic signed [spq_pkg::DATA_W-1:0] removed_priority,
    input logic [1:0]                        status,
    input logic [spq_pkg::OCC_W-1:0]         occupancy
);
    import spq_pkg::*;

    // A held-back result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A refused command returns no entry.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_DONE) |->
            (removed_value == '0) && (removed_priority == '0))
        else $error("refused command returned an entry");

    // Underflow only happens on an empty queue.
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_UNDERFLOW) |-> occupancy == '0)
        else $error("underflow reported with entries held");

    // Successive results differ in occupancy by at most one entry.
    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) ##1 out_valid |->
            (occupancy == $past(occupancy, 1)) ||
            (occupancy == $past(occupancy, 1) + OCC_W'(1)) ||
            (occupancy == $past(occupancy, 1) - OCC_W'(1)))
        else $error("occupancy jumped by more than one");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .removed_value    (removed_value),
    .removed_priority (removed_priority),
    .status           (status),
    .occupancy        (occupancy)
);
